### hw/rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the segment capacity reservation block.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

  localparam int unsigned MAX_SEGMENTS = 1024;
  // Block size is a power of two: block index and offset come from bit slices.
  localparam int unsigned BLK_W        = 5;
  localparam int unsigned BLK_SEGS     = 1 << BLK_W;

  localparam int unsigned CAP_W   = 16;
  localparam int unsigned SEG_W   = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET      = 16'd1;
  localparam logic [SEG_W-1:0] SEGMENT_COUNT_RESET = 11'd1024;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;   // write one memory entry of the clearing sweep
    logic load;       // latch a new request, start the walk
    logic blk_chk;    // fold a whole block minimum into the least value
    logic seg_rd;     // read the segment at the walk pointer
    logic seg_chk;    // fold the read segment into the least value
    logic blk_upd;    // subtract from a whole block lazily
    logic seg_upd;    // write back the read segment minus the amount
    logic rewind;     // walk pointer back to the range start
    logic respond;    // load the result register
  } scr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cfg_wr;     // a register write landed
    logic clr_last;   // clearing sweep at its last entry
    logic done;       // walk pointer reached the range end
    logic full_blk;   // walk pointer at a block fully inside the range
    logic reject;     // least value over the range is below the amount
    logic out_free;   // result register can take a result
  } scr_sts_t;

endpackage

`default_nettype wire

### hw/rtl/scr_ctrl.sv
// ----------------------------------------------------------------------------
// scr_ctrl
// Sequencer: clearing sweep, check walk, update walk and response.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire scr_pkg::scr_sts_t sts_i,
  output scr_pkg::scr_cmd_t      cmd_o
);
  import scr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_CHK_ISSUE = 7'b0000100,
    S_CHK_EVAL  = 7'b0001000,
    S_UPD_ISSUE = 7'b0010000,
    S_UPD_WRITE = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK_ISSUE;
        end
      end
      S_CHK_ISSUE: begin
        if (sts_i.done) begin
          cmd_o.rewind = 1'b1;
          state_d      = S_UPD_ISSUE;
        end else if (sts_i.full_blk) begin
          cmd_o.blk_chk = 1'b1;
        end else begin
          cmd_o.seg_rd = 1'b1;
          state_d      = S_CHK_EVAL;
        end
      end
      S_CHK_EVAL: begin
        cmd_o.seg_chk = 1'b1;
        state_d       = S_CHK_ISSUE;
      end
      S_UPD_ISSUE: begin
        // a rejected request (least < amount) skips the update walk
        if (sts_i.done || sts_i.reject) begin
          state_d = S_RESP;
        end else if (sts_i.full_blk) begin
          cmd_o.blk_upd = 1'b1;
        end else begin
          cmd_o.seg_rd = 1'b1;
          state_d      = S_UPD_WRITE;
        end
      end
      S_UPD_WRITE: begin
        cmd_o.seg_upd = 1'b1;
        state_d       = S_UPD_ISSUE;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a write to the capacity or segment count register reinitializes the segment row
    if (sts_i.cfg_wr) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

### hw/rtl/scr_datapath.sv
// ----------------------------------------------------------------------------
// scr_datapath
// Segment memory, block minimums, pending subtractions, walk pointer,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_datapath #(
  parameter int unsigned MaxSegments = scr_pkg::MAX_SEGMENTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [scr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [scr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [scr_pkg::CAP_W-1:0]      amount_i,
  input  wire logic [scr_pkg::SEG_W-1:0]      range_start_i,
  input  wire logic [scr_pkg::SEG_W-1:0]      range_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                accepted_o,
  input  wire scr_pkg::scr_cmd_t              cmd_i,
  output scr_pkg::scr_sts_t                   sts_o
);
  import scr_pkg::*;

  localparam int unsigned AddrW     = $clog2(MaxSegments);
  localparam int unsigned NumBlocks = (MaxSegments + BLK_SEGS - 1) / BLK_SEGS;
  localparam int unsigned BlkIdxW   = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned MaxW      = $clog2(MaxSegments + 1);
  localparam int unsigned CntW      = (MaxW > SEG_W) ? MaxW : SEG_W;

  // Configuration registers
  logic [CAP_W-1:0] cap_q;
  logic [SEG_W-1:0] segcnt_q;
  logic             cfg_hit;

  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == CFG_CAPACITY || cfg_index_i == CFG_SEGMENT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAPACITY_RESET;
      segcnt_q <= SEGMENT_COUNT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CAPACITY)      cap_q    <= cfg_data_i[CAP_W-1:0];
      if (cfg_index_i == CFG_SEGMENT_COUNT) segcnt_q <= cfg_data_i[SEG_W-1:0];
    end
  end

  // Clearing sweep counter
  logic [AddrW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           clr_q <= '0;
    else if (cfg_hit)      clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + AddrW'(1);
  end

  // Request registers, range end clamped to the segments in use
  logic [CAP_W-1:0] amt_q;
  logic [CntW-1:0]  start_q, end_q, ptr_q;
  logic [CntW-1:0]  used_n, req_end;

  assign used_n  = (CntW'(segcnt_q) > CntW'(MaxSegments)) ? CntW'(MaxSegments)
                                                           : CntW'(segcnt_q);
  assign req_end = (CntW'(range_end_i) > used_n) ? used_n : CntW'(range_end_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      amt_q   <= amount_i;
      start_q <= CntW'(range_start_i);
      end_q   <= req_end;
    end
  end

  // Walk pointer and its block
  logic [CntW-1:0]    ptr_shift;
  logic [BlkIdxW-1:0] blk;
  logic [CntW:0]      ptr_blk_end;
  logic               full_blk;

  assign ptr_shift   = ptr_q >> BLK_W;
  assign blk         = ptr_shift[BlkIdxW-1:0];
  assign ptr_blk_end = (CntW+1)'(ptr_q) + (CntW+1)'(BLK_SEGS);
  assign full_blk    = (ptr_q[BLK_W-1:0] == '0) && (ptr_blk_end <= (CntW+1)'(end_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load)                         ptr_q <= CntW'(range_start_i);
    else if (cmd_i.rewind)                  ptr_q <= start_q;
    else if (cmd_i.blk_chk || cmd_i.blk_upd) ptr_q <= ptr_blk_end[CntW-1:0];
    else if (cmd_i.seg_chk || cmd_i.seg_upd) ptr_q <= ptr_q + CntW'(1);
  end

  // Segment memory
  logic [CAP_W-1:0] seg_mem [MaxSegments];
  logic [CAP_W-1:0] rdata_q;
  logic [CAP_W-1:0] seg_new;
  logic [AddrW-1:0] addr;

  assign addr    = ptr_q[AddrW-1:0];
  assign seg_new = rdata_q - amt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step)      seg_mem[clr_q] <= cap_q;
    else if (cmd_i.seg_upd)  seg_mem[addr]  <= seg_new;
    if (cmd_i.seg_rd)        rdata_q <= seg_mem[addr];
  end

  // Least free capacity over the range
  logic [CAP_W-1:0] least_q;
  logic             reject;

  assign reject = (least_q < amt_q);

  // Block minimums and pending subtractions
  logic [CAP_W-1:0] bmin_q [NumBlocks];
  logic [CAP_W-1:0] pend_q [NumBlocks];
  logic [CAP_W-1:0] eff_chk, eff_upd;

  assign eff_chk = rdata_q - pend_q[blk];
  assign eff_upd = seg_new - pend_q[blk];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBlocks; b++) begin
        bmin_q[b] <= CAPACITY_RESET;
        pend_q[b] <= '0;
      end
    end else if (cmd_i.clr_step) begin
      for (int b = 0; b < NumBlocks; b++) begin
        bmin_q[b] <= cap_q;
        pend_q[b] <= '0;
      end
    end else if (cmd_i.blk_upd && !reject) begin
      bmin_q[blk] <= bmin_q[blk] - amt_q;
      pend_q[blk] <= pend_q[blk] + amt_q;
    end else if (cmd_i.seg_upd && !reject) begin
      if (eff_upd < bmin_q[blk]) bmin_q[blk] <= eff_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load)                                      least_q <= '1;
    else if (cmd_i.blk_chk && bmin_q[blk] < least_q)     least_q <= bmin_q[blk];
    else if (cmd_i.seg_chk && eff_chk < least_q)         least_q <= eff_chk;
  end

  // Result register
  logic out_valid_q, accepted_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                  out_valid_q <= 1'b0;
    else if (cmd_i.respond)       out_valid_q <= 1'b1;
    else if (out_ready_i)         out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) accepted_q <= !reject;
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  // Status
  always_comb begin
    sts_o          = '0;
    sts_o.cfg_wr   = cfg_hit;
    sts_o.clr_last = (clr_q == AddrW'(MaxSegments - 1));
    sts_o.done     = (ptr_q >= end_q);
    sts_o.full_blk = full_blk;
    sts_o.reject   = reject;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

### hw/rtl/segment_capacity_reservation.sv
// Each segment of a partial block takes an issue state and an evaluate or write
// state per walk (one port of the segment memory), a whole block only the issue
// state; a rejected request skips the update walk.
// Throughput: one request at a time, the next is taken the cycle after the result
// is loaded, later while the result register stalls. Reset and every write to the
// capacity or segment count register start a clearing sweep with no request taken.
// ----------------------------------------------------------------------------
// segment_capacity_reservation
// Admission control over a row of segments with block minimums and lazy
// block subtractions.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_capacity_reservation #(
  parameter int unsigned MaxSegments = scr_pkg::MAX_SEGMENTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [scr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [scr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [scr_pkg::CAP_W-1:0]      amount_i,
  input  wire logic [scr_pkg::SEG_W-1:0]      range_start_i,
  input  wire logic [scr_pkg::SEG_W-1:0]      range_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                accepted_o
);
  import scr_pkg::*;

  scr_cmd_t cmd;
  scr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  scr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scr_datapath #(
    .MaxSegments (MaxSegments)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .amount_i      (amount_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

### hw/rtl/scr_checker.sv
// ----------------------------------------------------------------------------
// scr_checker
// Port level checks of the reservation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_valid_i,
  input wire logic [scr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           accepted_o
);
  import scr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request is in work");

  // a write to the capacity or segment count register starts the clearing sweep
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == CFG_CAPACITY || cfg_index_i == CFG_SEGMENT_COUNT)
    |=> !in_ready_o)
    else $error("input ready during clearing sweep");

  // no result in the cycle right after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind segment_capacity_reservation scr_checker u_scr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_index_i (cfg_index_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives reservation requests with random pacing into the capacity
// reservation block, predicts each grant decision from a local copy of the
// segment state and compares every returned decision in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import scr_pkg::*;

  localparam int NBLK = MAX_SEGMENTS / BLK_SEGS;

  // register indexes outside the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CAP_W-1:0]      amount;
  logic [SEG_W-1:0]      range_start;
  logic [SEG_W-1:0]      range_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  accepted;

  // Predictor state
  logic [CAP_W-1:0] cap_q;
  logic [SEG_W-1:0] nseg_q;
  logic [CAP_W-1:0] seg_free[MAX_SEGMENTS];
  logic [CAP_W-1:0] blk_min[NBLK];
  logic [CAP_W-1:0] blk_pend[NBLK];

  bit grant_queue[$];
  int errors;
  bit hold_off;
  bit use_gaps;

  segment_capacity_reservation DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .amount_i     (amount),
    .range_start_i(range_start),
    .range_end_i  (range_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_o   (accepted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung run ends with FAIL
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic void clear_model();
    for (int i = 0; i < MAX_SEGMENTS; i++) seg_free[i] = cap_q;
    for (int b = 0; b < NBLK; b++) begin
      blk_min[b]  = cap_q;
      blk_pend[b] = '0;
    end
  endfunction

  // Grant decision with lazy block subtraction, updates local state
  function automatic bit predict_grant(logic [CAP_W-1:0] amt, logic [SEG_W-1:0] s,
                                       logic [SEG_W-1:0] e);
    int unsigned n, lo, hi, i, b, least;
    logic [CAP_W-1:0] eff;
    n  = (nseg_q > SEG_W'(MAX_SEGMENTS)) ? MAX_SEGMENTS : 32'(nseg_q);
    lo = 32'(s);
    hi = (32'(e) > n) ? n : 32'(e);
    least = 32'hFFFF_FFFF;
    if (lo >= hi) return 1'b1;
    i = lo;
    while (i < hi) begin
      b = i / BLK_SEGS;
      if (i % BLK_SEGS == 0 && i + BLK_SEGS <= hi) begin
        if (32'(blk_min[b]) < least) least = 32'(blk_min[b]);
        i += BLK_SEGS;
      end else begin
        eff = seg_free[i] - blk_pend[b];
        if (32'(eff) < least) least = 32'(eff);
        i++;
      end
    end
    if (least < 32'(amt)) return 1'b0;
    i = lo;
    while (i < hi) begin
      b = i / BLK_SEGS;
      if (i % BLK_SEGS == 0 && i + BLK_SEGS <= hi) begin
        blk_min[b]  = blk_min[b] - amt;
        blk_pend[b] = blk_pend[b] + amt;
        i += BLK_SEGS;
      end else begin
        seg_free[i] = seg_free[i] - amt;
        eff = seg_free[i] - blk_pend[b];
        if (eff < blk_min[b]) blk_min[b] = eff;
        i++;
      end
    end
    return 1'b1;
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Send one request transaction, record the expected decision at acceptance;
  // valid stays up after acceptance until drain() or a gap in the next call drops it
  task automatic send_request(input logic [CAP_W-1:0] amt, input logic [SEG_W-1:0] s,
                              input logic [SEG_W-1:0] e);
    int gap;
    gap = use_gaps ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid    <= 1'b1;
    amount      <= amt;
    range_start <= s;
    range_end   <= e;
    do @(posedge clk); while (!in_ready);
    grant_queue.insert(grant_queue.size(), predict_grant(amt, s, e));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    wait_cycles(40);
  endtask

  // Register write, only while idle; a capacity or segment count write triggers a clearing sweep
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CAPACITY) cap_q = val;
    else if (idx == CFG_SEGMENT_COUNT) nseg_q = val[SEG_W-1:0];
    if (idx == CFG_CAPACITY || idx == CFG_SEGMENT_COUNT) clear_model();
  endtask

  // Receiver: a random wait after each result while gaps are on, plus a long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        wait_cycles(3000);
        hold_off = 1'b0;
        out_ready <= 1'b1;
      end else if (use_gaps && out_valid && out_ready) begin
        gap = int'($urandom_range(0, 19));
        if (gap > 0) begin
          out_ready <= 1'b0;
          wait_cycles(gap);
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Decision checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) report("unexpected decision", int'(accepted), -1);
      else begin
        bit want;
        want = grant_queue.pop_front();
        if (accepted !== want) report("accepted", int'(accepted), int'(want));
      end
    end
  end

  task automatic random_request(input int n_used);
    logic [CAP_W-1:0] amt;
    int s, e;
    // mostly in-range requests, some past the end and some empty
    s = int'($urandom_range(0, n_used));
    e = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047))
                                    : int'($urandom_range(s, n_used));
    amt = ($urandom_range(0, 3) == 0) ? CAP_W'($urandom())
                                      : CAP_W'($urandom_range(0, cap_q / 4 + 1));
    send_request(amt, s[SEG_W-1:0], e[SEG_W-1:0]);
  endtask

  task automatic test_reset_state();
    send_request(16'd1, 11'd0, 11'd1);
    send_request(16'd1, 11'd0, 11'd1);
    send_request(16'd0, 11'd0, 11'd1024);
    send_request(16'd1, 11'd1, 11'd1024);
    send_request(16'hFFFF, 11'd5, 11'd5);
  endtask

  task automatic test_directed();
    write_reg(CFG_CAPACITY, 16'hFFFF);
    send_request(16'hFFFF, 11'd0, 11'd32);
    send_request(16'd1, 11'd0, 11'd1);
    send_request(16'h7FFF, 11'd30, 11'd70);
    send_request(16'h8000, 11'd40, 11'd41);
    send_request(16'h8000, 11'd64, 11'd96);
    send_request(16'd0, 11'd0, 11'd2047);
    send_request(16'h1234, 11'd1000, 11'd2047);
    send_request(16'd5, 11'd1024, 11'd1024);
    send_request(16'd5, 11'd2047, 11'd3);
    write_reg(CFG_SEGMENT_COUNT, 16'd1);
    send_request(16'd7, 11'd0, 11'd1024);
    send_request(16'hFFFF, 11'd0, 11'd1);
    write_reg(CFG_SEGMENT_COUNT, 16'd0);
    send_request(16'd1, 11'd0, 11'd1024);
    write_reg(CFG_SEGMENT_COUNT, 16'h07FF);
    send_request(16'd1, 11'd1000, 11'h7FF);
    write_reg(CFG_SPARE_LO, 16'h5555);
    send_request(16'hAAAA, 11'h2AA, 11'h555);
    write_reg(CFG_SPARE_HI, 16'hAAAA);
    send_request(16'h5555, 11'h555, 11'h7FF);
    write_reg(CFG_CAPACITY, 16'd1);
    send_request(16'd1, 11'd0, 11'd1);
  endtask

  task automatic test_random();
    int cfg_caps[5] = '{1, 65535, 100, 1000, 40000};
    int cfg_segs[5] = '{1024, 1, 40, 300, 1024};
    use_gaps = 1'b1;
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_SEGMENT_COUNT, CFG_DATA_W'(cfg_segs[p]));
      write_reg(CFG_CAPACITY, CFG_DATA_W'(cfg_caps[p]));
      for (int k = 0; k < 250; k++) begin
        // short stretches without idling
        use_gaps = (k % 50) >= 10;
        random_request((nseg_q > SEG_W'(MAX_SEGMENTS)) ? int'(MAX_SEGMENTS)
                                                       : int'(nseg_q));
      end
    end
  endtask

  task automatic test_backpressure();
    use_gaps = 1'b0;
    drain();
    hold_off = 1'b1;
    for (int k = 0; k < 20; k++) send_request(16'd1, 11'd0, 11'd8);
    use_gaps = 1'b1;
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    use_gaps = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    amount = '0;
    range_start = '0;
    range_end = '0;
    cap_q = CAPACITY_RESET;
    nseg_q = SEGMENT_COUNT_RESET;
    clear_model();
    wait_cycles(8);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/scr_pkg.sv
hw/rtl/scr_ctrl.sv
hw/rtl/scr_datapath.sv
hw/rtl/segment_capacity_reservation.sv
hw/rtl/scr_checker.sv
tb/testbench.sv
